@@ hdl/oaht_pkg.sv @@
// Shared types and constants for the open-addressing hash table.
// Holds the slot count, entry layout, operation and status codes.
// No dependencies.
package oaht_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int KIND_W     = 2;
    localparam int KEY_W      = 32;
    localparam int HASH_W     = 32;
    localparam int VAL_W      = 64;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;
    localparam int LIM_W      = 7;
    localparam int CMP_W      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [LIM_W-1:0] LOAD_LIMIT_RESET = LIM_W'(48);
    localparam logic [0:0]       REG_LOAD_LIMIT   = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NEW       = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_REMOVED   = 3'd4,
        STAT_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    typedef struct packed {
        mark_t             mark;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } entry_t;

endpackage

@@ hdl/open_addressing_hash_table_top.sv @@
// Hash table with linear probing and tombstones; slot state in one synchronous RAM.
// Depends on oaht_pkg.
//
// After reset the block sweeps the slot RAM to empty, one slot a cycle, and takes no item
// until that is done; load_limit can be written meanwhile. Each item then issues the first
// RAM read at acceptance, probes one slot per cycle (the RAM's single read port walks the
// probe chain), from 1 to SLOTS slots, and hands the result to the output register once
// the output is free. A lookup or remove on a table with no slot filled since reset, and an
// unused kind, skip the probe. One item is in flight at a time; the next is taken while the
// previous result still waits at the output.
module open_addressing_hash_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [oaht_pkg::KIND_W-1:0]       kind,
    input  logic [oaht_pkg::KEY_W-1:0]        key_id,
    input  logic [oaht_pkg::HASH_W-1:0]       key_hash,
    input  logic [oaht_pkg::VAL_W-1:0]        value,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [oaht_pkg::STATUS_W-1:0]     status,
    output logic [oaht_pkg::VAL_W-1:0]        value_out,
    output logic [oaht_pkg::SLOT_OUT_W-1:0]   slot,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [oaht_pkg::ADDR_W-1:0]       paddr,
    input  logic [oaht_pkg::DATA_W-1:0]       pwdata,
    output logic [oaht_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import oaht_pkg::*;

    // slot RAM
    entry_t              mem [SLOTS];
    entry_t              rd_data_reg;
    logic [SLOT_W-1:0]   rd_addr;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    entry_t              mem_wdata;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]   cnt_reg, cnt_next;
    logic                tomb_seen_reg, tomb_seen_next;
    logic [SLOT_W-1:0]   tomb_at_reg, tomb_at_next;
    logic [CNT_W-1:0]    used_count_reg, used_count_next;
    logic [LIM_W-1:0]    load_limit_reg;

    kind_t               kind_reg;
    logic [KEY_W-1:0]    id_reg;
    logic [VAL_W-1:0]    val_reg;

    status_t             res_status_reg, res_status_next;
    logic [VAL_W-1:0]    res_value_reg, res_value_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [VAL_W-1:0]    out_value_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    logic                in_xfer;
    logic                out_free;
    logic                needs_probe;
    logic                is_empty, is_tomb, is_hit;
    logic                probe_last, probe_end;
    logic                tomb_any;
    logic [SLOT_W-1:0]   tomb_pos;
    logic                room;
    logic                cfg_write;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign value_out = out_value_reg;
    assign slot      = SLOT_OUT_W'(out_slot_reg);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LOAD_LIMIT);
    assign prdata    = (paddr[2] == REG_LOAD_LIMIT) ? DATA_W'(load_limit_reg) : '0;

    // item classification at acceptance
    always_comb
    begin
        unique case (kind)
            KIND_INSERT: needs_probe = 1'b1;
            KIND_LOOKUP,
            KIND_REMOVE: needs_probe = (used_count_reg != '0);
            default:     needs_probe = 1'b0;
        endcase
    end

    // probe step on the entry read last cycle
    assign is_empty   = (rd_data_reg.mark == MARK_EMPTY);
    assign is_tomb    = (rd_data_reg.mark == MARK_TOMB);
    assign is_hit     = (rd_data_reg.mark == MARK_LIVE) && (rd_data_reg.key == id_reg);
    assign probe_last = (cnt_reg == SLOT_W'(SLOTS - 1));
    assign probe_end  = is_empty || is_hit || probe_last;
    assign tomb_any   = tomb_seen_reg || is_tomb;
    assign tomb_pos   = tomb_seen_reg ? tomb_at_reg : idx_reg;
    assign room       = CMP_W'(used_count_reg) < CMP_W'(load_limit_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_cnt_reg == SLOT_W'(SLOTS - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (in_xfer)
                    state_next = needs_probe ? S_PROBE : S_DONE;
            S_PROBE:
                if (probe_end)
                    state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_CLEAR;
        endcase
    end

    // datapath control
    always_comb
    begin
        rd_addr         = (state_reg == S_IDLE) ? key_hash[SLOT_W-1:0] : idx_reg + 1'b1;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = '{mark: MARK_LIVE, key: id_reg, value: val_reg};
        clr_cnt_next    = clr_cnt_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        tomb_seen_next  = tomb_seen_reg;
        tomb_at_next    = tomb_at_reg;
        used_count_next = used_count_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '{mark: MARK_EMPTY, key: '0, value: '0};
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                idx_next        = key_hash[SLOT_W-1:0];
                cnt_next        = '0;
                tomb_seen_next  = 1'b0;
                res_status_next = STAT_NOT_FOUND;
                res_value_next  = '0;
                res_slot_next   = '0;
            end
            S_PROBE:
            begin
                if (!probe_end)
                begin
                    idx_next       = idx_reg + 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    tomb_seen_next = tomb_any;
                    tomb_at_next   = tomb_pos;
                end
                else
                begin
                    unique case (kind_reg)
                        KIND_INSERT:
                        begin
                            priority if (is_hit)
                            begin
                                mem_we          = 1'b1;
                                res_status_next = STAT_UPDATED;
                                res_slot_next   = idx_reg;
                            end
                            else if (tomb_any)
                            begin
                                // reuse the first tombstone on the chain
                                mem_we          = 1'b1;
                                mem_waddr       = tomb_pos;
                                res_status_next = STAT_NEW;
                                res_slot_next   = tomb_pos;
                            end
                            else if (is_empty && room)
                            begin
                                mem_we          = 1'b1;
                                used_count_next = used_count_reg + 1'b1;
                                res_status_next = STAT_NEW;
                                res_slot_next   = idx_reg;
                            end
                            else
                            begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            if (is_hit)
                            begin
                                res_status_next = STAT_FOUND;
                                res_value_next  = rd_data_reg.value;
                                res_slot_next   = idx_reg;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (is_hit)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = '{mark: MARK_TOMB, key: rd_data_reg.key,
                                                    value: rd_data_reg.value};
                                res_status_next = STAT_REMOVED;
                                res_slot_next   = idx_reg;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // slot RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            used_count_reg <= '0;
            load_limit_reg <= LOAD_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            used_count_reg <= used_count_next;
            if (cfg_write)
                load_limit_reg <= pwdata[LIM_W-1:0];
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        tomb_seen_reg  <= tomb_seen_next;
        tomb_at_reg    <= tomb_at_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        if (in_xfer)
        begin
            kind_reg <= kind_t'(kind);
            id_reg   <= key_id;
            val_reg  <= value;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    // checks
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("slot RAM written while idle");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(used_count_reg) <= CMP_W'(SLOTS))
        else $error("used count beyond slot count");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_count_reg) |->
            ($past(state_reg) == S_PROBE)
            && (used_count_reg == $past(used_count_reg) + CNT_W'(1)))
        else $error("used count moved other than by one insert");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result transfer raised outside completion");

endmodule
